// ===== rtl/core/hcpt_pkg.sv =====
// Package: widths, reset values and register codes of the hysteresis crossing trigger.
package hcpt_pkg;

    localparam int WINDOW_DEPTH = 5;
    localparam int SAMPLE_BITS  = 12;

    localparam int TOL_BITS    = 11;
    localparam int PERIOD_BITS = 8;
    localparam int LOCKOUT_BITS = 16;
    localparam int TIME_BITS   = 32;
    localparam int DATA_BITS   = 32;
    localparam int CFG_ADDR_BITS = 4;

    localparam int POS_BITS = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_BITS = ((SAMPLE_BITS > TOL_BITS) ? SAMPLE_BITS : TOL_BITS) + 1;

    localparam logic [SAMPLE_BITS-1:0]  THRESHOLD_RST = SAMPLE_BITS'(2000);
    localparam logic [TOL_BITS-1:0]     TOLERANCE_RST = TOL_BITS'(50);
    localparam logic [PERIOD_BITS-1:0]  PERIOD_RST    = PERIOD_BITS'(5);
    localparam logic [LOCKOUT_BITS-1:0] LOCKOUT_RST   = LOCKOUT_BITS'(500);

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_TOLERANCE = 2'd1,
        REG_PERIOD    = 2'd2,
        REG_LOCKOUT   = 2'd3
    } t_reg_idx;

    typedef enum logic {
        CMD_SAMPLE  = 1'b0,
        CMD_RESTART = 1'b1
    } t_cmd;

endpackage

// ===== rtl/core/hcpt_if.sv =====
// Interfaces: sample input channel and result output channel.
interface hcpt_in_if
    import hcpt_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_BITS-1:0]   now_ms;
    logic [TIME_BITS-1:0]   last_pulse_ms;

    modport source (output valid, output cmd, output sample, output now_ms,
                    output last_pulse_ms, input ready);
    modport sink   (input valid, input cmd, input sample, input now_ms,
                    input last_pulse_ms, output ready);
endinterface

interface hcpt_out_if;
    logic valid;
    logic ready;
    logic crossed;
    logic pulse_request;
    logic waiting_to_rise;

    modport source (output valid, output crossed, output pulse_request,
                    output waiting_to_rise, input ready);
    modport sink   (input valid, input crossed, input pulse_request,
                    input waiting_to_rise, output ready);
endinterface

// ===== rtl/core/hysteresis_crossing_pulse_trigger.sv =====
// Hysteresis crossing trigger: takes one word per cycle; each word is
// captured in an input register and its result is written to the result
// register once that register is empty or its result is taken. The
// window, mark and phase update on the same edge as the result, so back-to-back words
// chain through them at full rate. The sink stalls only when both registers
// are full and the result is not taken. Registers sit on the APB port at
// byte offsets 0x0 threshold, 0x4 tolerance, 0x8 crossing period, 0xC lockout.
module hysteresis_crossing_pulse_trigger
    import hcpt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    hcpt_in_if.sink                  i_in,
    hcpt_out_if.source               o_out,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0]     pwdata,
    output logic [DATA_BITS-1:0]     prdata,
    output logic                     pready
);

    logic [SAMPLE_BITS-1:0]  r_threshold;
    logic [TOL_BITS-1:0]     r_tolerance;
    logic [PERIOD_BITS-1:0]  r_period;
    logic [LOCKOUT_BITS-1:0] r_lockout;

    logic                   r_in_vld;
    logic                   r_cmd;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [TIME_BITS-1:0]   r_now;
    logic [TIME_BITS-1:0]   r_last;

    logic [SAMPLE_BITS-1:0] r_window [WINDOW_DEPTH];
    logic [POS_BITS-1:0]    r_wpos;
    logic                   r_marked_low;
    logic [PERIOD_BITS-1:0] r_phase;

    logic r_out_vld;
    logic r_crossed;
    logic r_pulse;

    logic [SAMPLE_BITS-1:0] n_window [WINDOW_DEPTH];
    logic [POS_BITS-1:0]    n_wpos;
    logic                   n_marked_low;
    logic [PERIOD_BITS-1:0] n_phase;
    logic                   n_crossed;
    logic                   n_pulse;

    logic                   advance;
    logic                   proc;
    logic                   wr_en;
    t_reg_idx               reg_idx;
    logic [SUM_BITS-1:0]    low_bound;
    logic [SUM_BITS-1:0]    high_bound;
    logic [SUM_BITS-1:0]    hi_sum;
    logic [WINDOW_DEPTH-1:0] below;
    logic [WINDOW_DEPTH-1:0] above;
    logic                   hit;
    logic [PERIOD_BITS:0]   phase_inc;
    logic [PERIOD_BITS-1:0] period_eff;
    logic                   period_done;
    logic [TIME_BITS-1:0]   expiry;
    logic [TIME_BITS-1:0]   delta;
    logic                   expired;

    // handshake
    assign advance    = !r_out_vld || o_out.ready;
    assign proc       = r_in_vld && advance;
    assign i_in.ready = !r_in_vld || advance;

    assign o_out.valid           = r_out_vld;
    assign o_out.crossed         = r_crossed;
    assign o_out.pulse_request   = r_pulse;
    assign o_out.waiting_to_rise = r_marked_low;

    // config port
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (reg_idx)
            REG_THRESHOLD: prdata = DATA_BITS'(r_threshold);
            REG_TOLERANCE: prdata = DATA_BITS'(r_tolerance);
            REG_PERIOD:    prdata = DATA_BITS'(r_period);
            REG_LOCKOUT:   prdata = DATA_BITS'(r_lockout);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_tolerance <= TOLERANCE_RST;
            r_period    <= PERIOD_RST;
            r_lockout   <= LOCKOUT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_THRESHOLD: r_threshold <= pwdata[SAMPLE_BITS-1:0];
                REG_TOLERANCE: r_tolerance <= pwdata[TOL_BITS-1:0];
                REG_PERIOD:    r_period    <= pwdata[PERIOD_BITS-1:0];
                REG_LOCKOUT:   r_lockout   <= pwdata[LOCKOUT_BITS-1:0];
                default:       r_threshold <= r_threshold;
            endcase
        end
    end

    // bounds, clamped to the sample range
    assign hi_sum = SUM_BITS'(r_threshold) + SUM_BITS'(r_tolerance);
    assign low_bound = (SUM_BITS'(r_threshold) > SUM_BITS'(r_tolerance)) ?
                       SUM_BITS'(r_threshold) - SUM_BITS'(r_tolerance) : '0;
    assign high_bound = (hi_sum > SUM_BITS'({SAMPLE_BITS{1'b1}})) ?
                        SUM_BITS'({SAMPLE_BITS{1'b1}}) : hi_sum;

    always_comb begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            n_window[i] = (r_wpos == POS_BITS'(i)) ? r_sample : r_window[i];
            below[i]    = SUM_BITS'(n_window[i]) < low_bound;
            above[i]    = SUM_BITS'(n_window[i]) > high_bound;
        end
    end

    assign hit    = r_marked_low ? (&above) : (&below);
    assign n_wpos = (r_wpos == POS_BITS'(WINDOW_DEPTH - 1)) ? '0 : r_wpos + 1'b1;

    // phase and lockout
    assign period_eff  = (r_period == '0) ? PERIOD_BITS'(1) : r_period;
    assign phase_inc   = {1'b0, r_phase} + 1'b1;
    assign period_done = phase_inc >= {1'b0, period_eff};
    assign expiry      = r_last + TIME_BITS'(r_lockout);
    assign delta       = expiry - r_now;
    assign expired     = (delta == '0) || delta[TIME_BITS-1];

    always_comb begin
        n_crossed    = 1'b0;
        n_pulse      = 1'b0;
        n_marked_low = r_marked_low;
        n_phase      = r_phase;
        if (t_cmd'(r_cmd) == CMD_RESTART) begin
            n_phase = '0;
        end else if (hit) begin
            n_crossed    = 1'b1;
            n_marked_low = !r_marked_low;
            if (period_done) begin
                n_pulse = expired;
                n_phase = '0;
            end else begin
                n_phase = phase_inc[PERIOD_BITS-1:0];
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_cmd    <= i_in.cmd;
            r_sample <= i_in.sample;
            r_now    <= i_in.now_ms;
            r_last   <= i_in.last_pulse_ms;
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_window[i] <= '0;
            end
            r_wpos       <= '0;
            r_marked_low <= 1'b0;
            r_phase      <= '0;
            r_out_vld    <= 1'b0;
            r_crossed    <= 1'b0;
            r_pulse      <= 1'b0;
        end else begin
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
            if (proc) begin
                if (t_cmd'(r_cmd) == CMD_RESTART) begin
                    r_wpos <= '0;
                end else begin
                    r_window <= n_window;
                    r_wpos   <= n_wpos;
                end
                r_marked_low <= n_marked_low;
                r_phase      <= n_phase;
                r_crossed    <= n_crossed;
                r_pulse      <= n_pulse;
            end
        end
    end

`ifndef SYNTH
    a_wpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpos <= POS_BITS'(WINDOW_DEPTH - 1))
        else $error("write position out of window");

    a_pulse_needs_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_pulse |-> r_crossed)
        else $error("pulse request without crossing");

    a_cross_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> (r_crossed == (r_marked_low != $past(r_marked_low))))
        else $error("mark toggle does not match crossing");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_vld && r_out_vld && !o_out.ready))
        else $error("input stalled with room in pipeline");

    a_restart_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && (t_cmd'(r_cmd) == CMD_RESTART) |=> (!r_crossed && r_phase == '0))
        else $error("restart produced crossing or kept phase");
`endif

endmodule
